@@ hw/rtl/sfmf_pkg.sv @@
package sfmf_pkg;

  localparam int MAX_PATTERN_DEFAULT = 16;
  localparam int MAX_TEXT_DEFAULT    = 1024;

  // Pattern storage is fixed by the two 64-bit pattern registers
  localparam int PATTERN_BYTES = 16;
  localparam int LEN_W         = 5;
  localparam int CFG_W         = 64;
  localparam int CFG_INDEX_W   = 2;
  localparam int RESULT_W      = 12;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH   = 2'd2;

  localparam logic signed [RESULT_W-1:0] NO_MATCH    = '1;
  localparam logic signed [RESULT_W-1:0] WHOLE_MATCH = '0;

  typedef struct packed {
    logic [LEN_W-1:0]                  length;  // effective length, 1..MAX_PATTERN
    logic [PATTERN_BYTES-1:0][7:0]     bytes;   // byte 0 in the lowest bits
  } pattern_cfg_t;

endpackage

@@ hw/rtl/sfmf_cfg_regs.sv @@
module sfmf_cfg_regs import sfmf_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output pattern_cfg_t           pattern
);

  logic [LEN_W-1:0] pattern_length;
  logic [CFG_W-1:0] pattern_low_bytes;
  logic [CFG_W-1:0] pattern_high_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= LEN_W'(1);
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LENGTH: pattern_length     <= cfg_data[LEN_W-1:0];
        REG_LOW:    pattern_low_bytes  <= cfg_data;
        REG_HIGH:   pattern_high_bytes <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // clamp to 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      pattern.length = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      pattern.length = LEN_W'(MAX_PATTERN);
    end else begin
      pattern.length = pattern_length;
    end
    pattern.bytes = {pattern_high_bytes, pattern_low_bytes};
  end

endmodule

@@ hw/rtl/sfmf_match.sv @@
module sfmf_match import sfmf_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
  input  logic [MAX_PATTERN-1:0][7:0] window,   // entry 0 newest
  input  pattern_cfg_t                pattern,
  output logic                        hit
);

  // one compare lane per candidate length, pick the configured one
  always_comb begin
    logic lane;
    hit = 1'b0;
    for (int len = 1; len <= MAX_PATTERN; len++) begin
      lane = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (window[len-1-i] != pattern.bytes[i]) begin
          lane = 1'b0;
        end
      end
      if (LEN_W'(len) == pattern.length) begin
        hit = lane;
      end
    end
  end

endmodule

@@ hw/rtl/substring_first_match_finder.sv @@
// Streaming first-occurrence substring finder. Text arrives one byte per
// transaction on the text channel (text_byte, last_byte) and is matched
// against a pattern of 1 to MAX_PATTERN bytes set through the register port
// (index 0: length, index 1: bytes 0-7, index 2: bytes 8-15, byte 0 in the
// low bits). On the transaction with last_byte set, one result goes out on
// the result channel: 0 when the whole text equals the pattern, otherwise
// the 1-based start of the first full occurrence, or -1 when none was found.
// Bytes past MAX_TEXT are dropped, though their last marker still closes the
// text. The block takes one text transaction per clock while text_stall is
// low; a result passes the input register, then the result register, after
// its last byte is accepted. text_stall rises only while a finished result
// is held by result_stall. Write registers only between texts.
module substring_first_match_finder import sfmf_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
  parameter int MAX_TEXT    = MAX_TEXT_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  // register write port
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  // text channel
  input  logic                       text_valid,
  output logic                       text_stall,
  input  logic [7:0]                 text_byte,
  input  logic                       last_byte,
  // result channel
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [RESULT_W-1:0] match_position
);

  localparam int POS_W = $clog2(MAX_TEXT + 1);

  pattern_cfg_t pattern;

  sfmf_cfg_regs #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pattern   (pattern)
  );

  // ---------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;   // work stage may retire the held byte
  logic       step;
  logic       take;

  assign advance    = !result_valid || !result_stall;
  assign step       = in_valid && advance;
  assign text_stall = in_valid && !advance;
  assign take       = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_byte <= text_byte;
      in_last <= last_byte;
    end
  end

  // ---------------------------------------------------------------
  // Text state and window compare
  // ---------------------------------------------------------------
  logic [MAX_PATTERN-1:0][7:0] window;
  logic [MAX_PATTERN-1:0][7:0] window_next;
  logic [POS_W-1:0]            text_position;
  logic [POS_W-1:0]            position_next;
  logic [POS_W-1:0]            first_match_start;
  logic [POS_W-1:0]            first_match_start_next;
  logic [POS_W-1:0]            start_calc;
  logic [POS_W-1:0]            len_ext;
  logic                        match_seen;
  logic                        match_seen_next;
  logic                        room;
  logic                        lane_hit;
  logic                        full_hit;
  logic                        whole_text;
  logic [POS_W+RESULT_W-1:0]   start_wide;
  logic signed [RESULT_W-1:0]  result_next;

  // newest byte enters at entry 0
  always_comb begin
    window_next[0] = in_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_next[k] = window[k-1];
    end
  end

  sfmf_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .window  (window_next),
    .pattern (pattern),
    .hit     (lane_hit)
  );

  always_comb begin
    room          = text_position < POS_W'(MAX_TEXT);
    position_next = text_position + POS_W'(1);
    len_ext       = POS_W'(pattern.length);
    // only window entries written in this text are compared
    full_hit      = room && (position_next >= len_ext) && lane_hit;
    start_calc    = position_next - len_ext + POS_W'(1);
    whole_text    = full_hit && (position_next == len_ext);

    match_seen_next        = match_seen || full_hit;
    first_match_start_next = (!match_seen && full_hit) ? start_calc : first_match_start;

    start_wide = {{RESULT_W{1'b0}}, first_match_start_next};
    if (whole_text) begin
      result_next = WHOLE_MATCH;
    end else if (match_seen_next) begin
      result_next = $signed(start_wide[RESULT_W-1:0]);
    end else begin
      result_next = NO_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_position <= '0;
      match_seen    <= 1'b0;
    end else if (step) begin
      if (in_last) begin
        // text closed, start fresh
        text_position <= '0;
        match_seen    <= 1'b0;
      end else begin
        if (room) begin
          text_position <= position_next;
        end
        match_seen <= match_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (room) begin
        window <= window_next;
      end
      first_match_start <= first_match_start_next;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && in_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      match_position <= result_next;
    end
  end

endmodule

@@ hw/rtl/sfmf_checker.sv @@
module sfmf_checker import sfmf_pkg::*; #(
  parameter int MAX_TEXT = MAX_TEXT_DEFAULT
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       text_stall,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic signed [RESULT_W-1:0] match_position
);

  localparam bit FITS = (MAX_TEXT < (1 << (RESULT_W - 1)));

  // held result must not move
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(match_position))
    else $error("stalled result changed");

  // nothing pending right after reset
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // text side backs up only behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    text_stall |-> result_valid && result_stall)
    else $error("text stalled without a held result");

  // result is -1 or non-negative
  assert property (@(posedge clk) disable iff (rst)
    result_valid && FITS |-> !match_position[RESULT_W-1] || match_position == NO_MATCH)
    else $error("result below -1");

endmodule

bind substring_first_match_finder sfmf_checker #(
  .MAX_TEXT (MAX_TEXT)
) u_sfmf_checker (
  .clk            (clk),
  .rst            (rst),
  .text_stall     (text_stall),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .match_position (match_position)
);
